@@ design/ridc_pkg.sv @@
// Shared types, constants and key packing for the rotation-invariant distinct counter.
package ridc_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int LANES       = 4;
    localparam int LANE_W      = $clog2(LANES);
    localparam int LANE_DEPTH  = (MAX_ENTRIES + LANES - 1) / LANES;
    localparam int ROW_W       = (LANE_DEPTH > 1) ? $clog2(LANE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int KEY_W       = 32;
    localparam int ELEM_W      = 8;
    localparam int UCNT_W      = 9;
    localparam int UCNT_MAX    = 511;
    localparam int NUM_ROT     = 4;

    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [LANES-1:0]  lane_vec_t;

    typedef struct packed {
        logic [ELEM_W-1:0] elem_0;
        logic [ELEM_W-1:0] elem_1;
        logic [ELEM_W-1:0] elem_2;
        logic [ELEM_W-1:0] elem_3;
        logic              last_matrix;
    } matrix_t;

    typedef struct packed {
        logic [UCNT_W-1:0] unique_count;
        logic              overflow;
    } result_t;

    typedef struct packed {
        logic rd_en;
        row_t rd_addr;
        logic wr_en;
        row_t wr_addr;
    } lane_cmd_t;

    // element order per rotation, first entry lands in the top byte
    localparam logic [1:0] ROT_ORDER [NUM_ROT][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd2, 2'd0, 2'd3, 2'd1},
        '{2'd3, 2'd2, 2'd1, 2'd0},
        '{2'd1, 2'd3, 2'd0, 2'd2}
    };

    function automatic key_t pack_rotation(matrix_t m, int r);
        logic [ELEM_W-1:0] e [4];
        key_t              acc;
        e[0] = m.elem_0;
        e[1] = m.elem_1;
        e[2] = m.elem_2;
        e[3] = m.elem_3;
        acc  = '0;
        for (int i = 0; i < 4; i++)
        begin
            acc = {acc[KEY_W-ELEM_W-1:0], e[ROT_ORDER[r][i]]};
        end
        return acc;
    endfunction

endpackage

@@ design/ridc_canon.sv @@
// Canonical key unit: maximum of the four rotation packings, two register stages.
module ridc_canon (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  ridc_pkg::matrix_t matrix,
    output ridc_pkg::key_t    key,
    output logic              key_valid
);

    ridc_pkg::key_t k0, k1, k2, k3;
    ridc_pkg::key_t m01_reg, m23_reg, key_reg;
    logic           v1_reg, v2_reg;

    always_comb
    begin
        k0 = ridc_pkg::pack_rotation(matrix, 0);
        k1 = ridc_pkg::pack_rotation(matrix, 1);
        k2 = ridc_pkg::pack_rotation(matrix, 2);
        k3 = ridc_pkg::pack_rotation(matrix, 3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= load;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m01_reg <= (k0 > k1) ? k0 : k1;
            m23_reg <= (k2 > k3) ? k2 : k3;
        end
        if (v1_reg)
        begin
            key_reg <= (m01_reg > m23_reg) ? m01_reg : m23_reg;
        end
    end

    assign key       = key_reg;
    assign key_valid = v2_reg;

endmodule

@@ design/ridc_lane.sv @@
// One search lane: a slice of the key table with registered read and key compare.
module ridc_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  ridc_pkg::lane_cmd_t cmd,
    input  ridc_pkg::key_t      wr_data,
    input  ridc_pkg::key_t      key,
    output logic                hit
);

    ridc_pkg::key_t mem [ridc_pkg::LANE_DEPTH];
    ridc_pkg::key_t rd_data_reg;
    logic           rd_vld_reg;
    logic           hit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[cmd.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.rd_en;
            hit_reg    <= rd_vld_reg && (rd_data_reg == key);
        end
    end

    assign hit = hit_reg;

endmodule

@@ design/rotation_invariant_distinct_counter_unit.sv @@
// Top level: item control, lane search sequencing, hit merge and result register.
//
// Usage: present a matrix item on matrix and raise start; the item is taken
// at the rising edge where start is high and busy is low. busy stays high
// until the item is fully processed. An item with last_matrix set produces
// one result on result, marked by done for exactly one cycle; other items
// produce none. The receiver cannot stall, so done is never held.
// Per item: the accept, the canonical key from the ridc_canon registers, a
// search over the ceil(n/4) rows that hold the n stored keys (four lanes
// read one row each per cycle), a drain of the lane read and compare
// registers, and the update; the result appears the cycle after the update.
// With an empty table the search and drain cycles are skipped.
// The search length is set by the single read port of each lane memory.
// Reset clears the count, the overflow flag and all control; the key
// table is not cleared, only entries written in the current set are read.
// After a result the count and overflow flag start over for the next set.
module rotation_invariant_distinct_counter_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ridc_pkg::matrix_t matrix,
    output logic              done,
    output ridc_pkg::result_t result
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CANON  = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_UPDATE = 3'd4;

    logic [2:0]          state_reg, state_next;
    ridc_pkg::cnt_t      count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic                found_reg, found_next;
    logic                last_reg;
    ridc_pkg::row_t      row_reg, row_next;
    ridc_pkg::row_t      last_row;
    logic                drain_reg, drain_next;
    logic                done_reg, done_next;
    ridc_pkg::result_t   result_reg, result_next;

    logic                accept;
    ridc_pkg::key_t      key;
    logic                key_valid;
    ridc_pkg::lane_vec_t hits;
    ridc_pkg::lane_vec_t wr_vec;
    ridc_pkg::lane_cmd_t cmd [ridc_pkg::LANES];
    logic                append;
    logic [31:0]         cnt_after;

    assign accept   = start && !busy;
    assign busy     = (state_reg != S_IDLE);
    assign last_row = ridc_pkg::row_t'((count_reg - 1'b1) >> ridc_pkg::LANE_W);
    assign append   = (state_reg == S_UPDATE) && !found_reg
                      && (32'(count_reg) < 32'(ridc_pkg::MAX_ENTRIES));

    ridc_canon u_canon (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .matrix    (matrix),
        .key       (key),
        .key_valid (key_valid)
    );

    always_comb
    begin
        for (int l = 0; l < ridc_pkg::LANES; l++)
        begin
            wr_vec[l]       = append
                              && (count_reg[ridc_pkg::LANE_W-1:0] == ridc_pkg::LANE_W'(l));
            cmd[l].rd_en    = (state_reg == S_SEARCH)
                              && (32'({row_reg, ridc_pkg::LANE_W'(l)}) < 32'(count_reg));
            cmd[l].rd_addr  = row_reg;
            cmd[l].wr_en    = wr_vec[l];
            cmd[l].wr_addr  = ridc_pkg::row_t'(count_reg >> ridc_pkg::LANE_W);
        end
    end

    for (genvar g = 0; g < ridc_pkg::LANES; g++)
    begin : g_lane
        ridc_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd[g]),
            .wr_data (key),
            .key     (key),
            .hit     (hits[g])
        );
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        found_next  = found_reg | (|hits);
        row_next    = row_reg;
        drain_next  = drain_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        cnt_after   = 32'(count_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CANON;
                end
            end
            S_CANON:
            begin
                found_next = 1'b0;
                row_next   = '0;
                drain_next = 1'b0;
                if (key_valid)
                begin
                    state_next = (count_reg == '0) ? S_UPDATE : S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (row_reg == last_row)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                drain_next = 1'b1;
                if (drain_reg)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                state_next = S_IDLE;
                if (!found_reg)
                begin
                    if (append)
                    begin
                        cnt_after = 32'(count_reg) + 32'd1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                count_next = ridc_pkg::cnt_t'(cnt_after);
                if (last_reg)
                begin
                    done_next                = 1'b1;
                    result_next.unique_count =
                        (cnt_after > 32'(ridc_pkg::UCNT_MAX)) ?
                        ridc_pkg::UCNT_W'(ridc_pkg::UCNT_MAX) :
                        cnt_after[ridc_pkg::UCNT_W-1:0];
                    result_next.overflow     = ovf_next;
                    count_next               = '0;
                    ovf_next                 = 1'b0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            found_reg <= 1'b0;
            row_reg   <= '0;
            drain_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            found_reg <= found_next;
            row_reg   <= row_next;
            drain_reg <= drain_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last_reg <= matrix.last_matrix;
        end
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_UPDATE))
        else $error("result strobe without an update cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(ridc_pkg::MAX_ENTRIES))
        else $error("entry count above table size");

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(wr_vec))
        else $error("more than one lane written");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after accept");

    a_no_write_when_found: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg && (state_reg == S_UPDATE) |-> (wr_vec == '0))
        else $error("matched key appended");

endmodule
